// ===== rtl/core/aeru_pkg.sv =====
// shared types and constants for the execute stage with register file and flags
// no dependencies
package aeru_pkg;

    localparam int unsigned REG_COUNT = 16;
    localparam int unsigned REG_IDX_W = 4;
    localparam int unsigned DATA_W    = 32;
    localparam int unsigned OFFSET_W  = 24;
    localparam int unsigned SEXT_W    = DATA_W - OFFSET_W - 2;

    localparam logic [REG_IDX_W-1:0] PC_INDEX = 4'hf;

    localparam logic [3:0] OP_AND    = 4'd0;
    localparam logic [3:0] OP_EOR    = 4'd1;
    localparam logic [3:0] OP_SUB    = 4'd2;
    localparam logic [3:0] OP_RSB    = 4'd3;
    localparam logic [3:0] OP_ADD    = 4'd4;
    localparam logic [3:0] OP_TST    = 4'd5;
    localparam logic [3:0] OP_TEQ    = 4'd6;
    localparam logic [3:0] OP_CMP    = 4'd7;
    localparam logic [3:0] OP_ORR    = 4'd8;
    localparam logic [3:0] OP_MOV    = 4'd9;
    localparam logic [3:0] OP_MUL    = 4'd10;
    localparam logic [3:0] OP_BRANCH = 4'd11;

    typedef struct packed {
        logic [3:0]           operation;
        logic [REG_IDX_W-1:0] dest_reg;
        logic [REG_IDX_W-1:0] first_reg;
        logic [DATA_W-1:0]    operand_two;
        logic                 shifter_carry;
        logic                 set_flags;
        logic [REG_IDX_W-1:0] mul_reg_m;
        logic [REG_IDX_W-1:0] mul_reg_s;
        logic                 accumulate;
        logic [OFFSET_W-1:0]  branch_offset;
    } instr_t;

    typedef struct packed {
        logic [DATA_W-1:0] result_value;
        logic              result_written;
        logic              flag_neg;
        logic              flag_zero;
        logic              flag_carry;
        logic [DATA_W-1:0] program_counter;
    } result_t;

    typedef struct packed {
        logic neg;
        logic zero;
        logic carry;
    } flags_t;

    typedef struct packed {
        logic                 en;
        logic [REG_IDX_W-1:0] addr_n;
        logic [REG_IDX_W-1:0] addr_m;
        logic [REG_IDX_W-1:0] addr_s;
    } rf_rd_t;

    typedef struct packed {
        logic                 en;
        logic [REG_IDX_W-1:0] addr;
        logic [DATA_W-1:0]    data;
    } rf_wr_t;

    typedef struct packed {
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] m;
        logic [DATA_W-1:0] s;
    } rf_ops_t;

endpackage

// ===== rtl/core/aeru_ram.sv =====
// generic single-write single-read ram with registered read data
// no dependencies
module aeru_ram #(
    parameter int unsigned WIDTH  = 32,
    parameter int unsigned DEPTH  = 16,
    parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/aeru_regfile.sv =====
// register file: three read copies, per-entry valid bits, same-edge bypass, pc copy
// depends on aeru_pkg and aeru_ram
module aeru_regfile
    import aeru_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  rf_rd_t            rd,
    input  rf_wr_t            wr,
    output rf_ops_t           ops,
    output logic [DATA_W-1:0] pc
);

    logic [DATA_W-1:0]    q_n;
    logic [DATA_W-1:0]    q_m;
    logic [DATA_W-1:0]    q_s;
    logic [REG_COUNT-1:0] valid_reg;
    logic [REG_COUNT-1:0] valid_next;
    logic [2:0]           byp_reg;
    logic [2:0]           byp_next;
    logic [2:0]           vld_reg;
    logic [2:0]           vld_next;
    logic [DATA_W-1:0]    byp_data_reg;
    logic [DATA_W-1:0]    pc_reg;
    logic [DATA_W-1:0]    pc_next;

    aeru_ram #(.WIDTH(DATA_W), .DEPTH(REG_COUNT)) u_ram_n (
        .clk     (clk),
        .wr_en   (wr.en),
        .wr_addr (wr.addr),
        .wr_data (wr.data),
        .rd_en   (rd.en),
        .rd_addr (rd.addr_n),
        .rd_data (q_n)
    );

    aeru_ram #(.WIDTH(DATA_W), .DEPTH(REG_COUNT)) u_ram_m (
        .clk     (clk),
        .wr_en   (wr.en),
        .wr_addr (wr.addr),
        .wr_data (wr.data),
        .rd_en   (rd.en),
        .rd_addr (rd.addr_m),
        .rd_data (q_m)
    );

    aeru_ram #(.WIDTH(DATA_W), .DEPTH(REG_COUNT)) u_ram_s (
        .clk     (clk),
        .wr_en   (wr.en),
        .wr_addr (wr.addr),
        .wr_data (wr.data),
        .rd_en   (rd.en),
        .rd_addr (rd.addr_s),
        .rd_data (q_s)
    );

    always_comb
    begin
        valid_next = valid_reg;
        if (wr.en)
        begin
            valid_next[wr.addr] = 1'b1;
        end
        byp_next = byp_reg;
        vld_next = vld_reg;
        if (rd.en)
        begin
            byp_next[0] = wr.en && (wr.addr == rd.addr_n);
            byp_next[1] = wr.en && (wr.addr == rd.addr_m);
            byp_next[2] = wr.en && (wr.addr == rd.addr_s);
            vld_next[0] = valid_reg[rd.addr_n];
            vld_next[1] = valid_reg[rd.addr_m];
            vld_next[2] = valid_reg[rd.addr_s];
        end
        pc_next = (wr.en && (wr.addr == PC_INDEX)) ? wr.data : pc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            byp_reg   <= '0;
            vld_reg   <= '0;
            pc_reg    <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            byp_reg   <= byp_next;
            vld_reg   <= vld_next;
            pc_reg    <= pc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            byp_data_reg <= wr.data;
        end
    end

    // never-written entries read as zero
    assign ops.a = byp_reg[0] ? byp_data_reg : (vld_reg[0] ? q_n : '0);
    assign ops.m = byp_reg[1] ? byp_data_reg : (vld_reg[1] ? q_m : '0);
    assign ops.s = byp_reg[2] ? byp_data_reg : (vld_reg[2] ? q_s : '0);
    assign pc    = pc_reg;

endmodule

// ===== rtl/core/aeru_alu.sv =====
// execute logic: data processing, multiply, branch and flag update
// depends on aeru_pkg
module aeru_alu
    import aeru_pkg::*;
(
    input  instr_t            item,
    input  rf_ops_t           ops,
    input  logic [DATA_W-1:0] pc,
    input  flags_t            flags,
    output result_t           res,
    output flags_t            flags_next,
    output rf_wr_t            wr
);

    logic [DATA_W:0]   sub_ab;
    logic [DATA_W:0]   sub_ba;
    logic [DATA_W:0]   sum_ab;
    logic [DATA_W-1:0] prod;
    logic [DATA_W-1:0] mul_res;
    logic [DATA_W-1:0] br_off;
    logic [DATA_W-1:0] br_res;
    logic              is_dp;

    assign sub_ab  = {1'b0, ops.a} - {1'b0, item.operand_two};
    assign sub_ba  = {1'b0, item.operand_two} - {1'b0, ops.a};
    assign sum_ab  = {1'b0, ops.a} + {1'b0, item.operand_two};
    assign prod    = ops.m * ops.s;
    assign mul_res = prod + (item.accumulate ? ops.a : '0);
    assign br_off  = {{SEXT_W{item.branch_offset[OFFSET_W-1]}}, item.branch_offset, 2'b00};
    assign br_res  = pc + br_off;
    assign is_dp   = item.operation inside {[OP_AND:OP_MOV]};

    always_comb
    begin
        logic [DATA_W-1:0] value;
        logic              written;
        logic              carry;
        value   = '0;
        written = 1'b0;
        carry   = item.shifter_carry;
        case (item.operation)
            OP_AND:
            begin
                value   = ops.a & item.operand_two;
                written = 1'b1;
            end
            OP_EOR:
            begin
                value   = ops.a ^ item.operand_two;
                written = 1'b1;
            end
            OP_SUB:
            begin
                value   = sub_ab[DATA_W-1:0];
                written = 1'b1;
                carry   = ~sub_ab[DATA_W];
            end
            OP_RSB:
            begin
                value   = sub_ba[DATA_W-1:0];
                written = 1'b1;
                carry   = ~sub_ba[DATA_W];
            end
            OP_ADD:
            begin
                value   = sum_ab[DATA_W-1:0];
                written = 1'b1;
                carry   = sum_ab[DATA_W];
            end
            OP_TST:
            begin
                value = ops.a & item.operand_two;
            end
            OP_TEQ:
            begin
                value = ops.a ^ item.operand_two;
            end
            OP_CMP:
            begin
                value = sub_ab[DATA_W-1:0];
                carry = ~sub_ab[DATA_W];
            end
            OP_ORR:
            begin
                value   = ops.a | item.operand_two;
                written = 1'b1;
            end
            OP_MOV:
            begin
                value   = item.operand_two;
                written = 1'b1;
            end
            OP_MUL:
            begin
                value   = mul_res;
                written = 1'b1;
            end
            OP_BRANCH:
            begin
                value   = br_res;
                written = 1'b1;
            end
            default:
            begin
                value   = '0;
                written = 1'b0;
            end
        endcase

        flags_next = flags;
        if (item.set_flags && (is_dp || (item.operation == OP_MUL)))
        begin
            flags_next.neg  = value[DATA_W-1];
            flags_next.zero = (value == '0);
            if (is_dp)
            begin
                flags_next.carry = carry;
            end
        end

        wr.en   = written;
        wr.addr = (item.operation == OP_BRANCH) ? PC_INDEX : item.dest_reg;
        wr.data = value;

        res.result_value    = value;
        res.result_written  = written;
        res.flag_neg        = flags_next.neg;
        res.flag_zero       = flags_next.zero;
        res.flag_carry      = flags_next.carry;
        res.program_counter = (written && (wr.addr == PC_INDEX)) ? value : pc;
    end

endmodule

// ===== rtl/core/arm_execute_alu_regfile.sv =====
// execute stage: an accepted instruction is held in the instruction register and its result
// beat in the result register; throughput one instruction per cycle while no stalled result
// beat blocks the single execute pass between them (register file written on the same edge)
// reset: all registers read as zero, flags cleared, no beat pending
// depends on aeru_pkg, aeru_regfile, aeru_alu
module arm_execute_alu_regfile
    import aeru_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    instr_valid,
    output logic    instr_stall,
    input  instr_t  instr,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    logic    exe_valid_reg;
    logic    exe_valid_next;
    instr_t  exe_item_reg;
    logic    result_valid_reg;
    logic    result_valid_next;
    result_t result_reg;
    flags_t  flags_reg;
    flags_t  flags_alu;
    result_t res_alu;
    rf_wr_t  wr_alu;
    rf_wr_t  wr;
    rf_rd_t  rd;
    rf_ops_t ops;
    logic [DATA_W-1:0] pc;
    logic    accept;
    logic    advance;

    assign advance     = exe_valid_reg && (!result_valid_reg || !result_stall);
    assign instr_stall = exe_valid_reg && !advance;
    assign accept      = instr_valid && !instr_stall;

    assign rd.en     = accept;
    assign rd.addr_n = instr.first_reg;
    assign rd.addr_m = instr.mul_reg_m;
    assign rd.addr_s = instr.mul_reg_s;

    assign wr.en   = advance && wr_alu.en;
    assign wr.addr = wr_alu.addr;
    assign wr.data = wr_alu.data;

    aeru_regfile u_regfile (
        .clk   (clk),
        .rst_n (rst_n),
        .rd    (rd),
        .wr    (wr),
        .ops   (ops),
        .pc    (pc)
    );

    aeru_alu u_alu (
        .item       (exe_item_reg),
        .ops        (ops),
        .pc         (pc),
        .flags      (flags_reg),
        .res        (res_alu),
        .flags_next (flags_alu),
        .wr         (wr_alu)
    );

    always_comb
    begin
        exe_valid_next = exe_valid_reg;
        if (accept)
        begin
            exe_valid_next = 1'b1;
        end
        else if (advance)
        begin
            exe_valid_next = 1'b0;
        end
        result_valid_next = result_valid_reg;
        if (advance)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exe_valid_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
            flags_reg        <= '0;
        end
        else
        begin
            exe_valid_reg    <= exe_valid_next;
            result_valid_reg <= result_valid_next;
            if (advance)
            begin
                flags_reg <= flags_alu;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            exe_item_reg <= instr;
        end
        if (advance)
        begin
            result_reg <= res_alu;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTHESIS
    a_hold_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (exe_valid_reg && result_valid_reg && result_stall) |-> instr_stall)
        else $error("instruction accepted while execute stage is blocked");

    a_advance_fills_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result_valid)
        else $error("executed instruction produced no result beat");

    a_branch_keeps_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (exe_item_reg.operation == OP_BRANCH)) |=> (flags_reg == $past(flags_reg)))
        else $error("branch changed the condition flags");

    a_pc_matches_copy: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (result.program_counter == pc))
        else $error("reported program counter differs from register file copy");
`endif

endmodule

// ===== sim/aeru_result_checker.sv =====
`timescale 1ns / 1ps
// result checker for the execute stage: mirrors register file and flags, predicts each result beat
// and compares it field by field; depends on aeru_pkg only
module aeru_result_checker
    import aeru_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    instr_valid,
    input  logic    instr_stall,
    input  instr_t  instr,
    input  logic    result_valid,
    input  logic    result_stall,
    input  result_t result,
    output int      errors,
    output int      outstanding,
    output int      checked
);

    logic [DATA_W-1:0] arch_regs [REG_COUNT];
    logic              flag_n;
    logic              flag_z;
    logic              flag_c;
    result_t           expected_results [$];
    int                fail_count = 0;
    int                queued = 0;
    int                compared = 0;

    assign errors      = fail_count;
    assign outstanding = queued;
    assign checked     = compared;

    function automatic result_t execute_instr(instr_t it);
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] val;
        logic [DATA_W-1:0] disp;
        logic              wr;
        logic              cy;
        logic              alu;
        result_t           r;
        a   = arch_regs[it.first_reg];
        val = '0;
        wr  = 1'b0;
        cy  = it.shifter_carry;
        alu = 1'b1;
        case (it.operation)
            OP_AND: begin val = a & it.operand_two; wr = 1'b1; end
            OP_EOR: begin val = a ^ it.operand_two; wr = 1'b1; end
            OP_SUB:
            begin
                val = a - it.operand_two;
                wr  = 1'b1;
                cy  = (a >= it.operand_two);
            end
            OP_RSB:
            begin
                val = it.operand_two - a;
                wr  = 1'b1;
                cy  = (it.operand_two >= a);
            end
            OP_ADD:
            begin
                {cy, val} = {1'b0, a} + {1'b0, it.operand_two};
                wr = 1'b1;
            end
            OP_TST: val = a & it.operand_two;
            OP_TEQ: val = a ^ it.operand_two;
            OP_CMP:
            begin
                val = a - it.operand_two;
                cy  = (a >= it.operand_two);
            end
            OP_ORR: begin val = a | it.operand_two; wr = 1'b1; end
            OP_MOV: begin val = it.operand_two; wr = 1'b1; end
            OP_MUL:
            begin
                alu = 1'b0;
                val = arch_regs[it.mul_reg_m] * arch_regs[it.mul_reg_s];
                if (it.accumulate)
                    val = val + a;
                wr = 1'b1;
                arch_regs[it.dest_reg] = val;
                if (it.set_flags)
                begin
                    flag_n = val[DATA_W-1];
                    flag_z = (val == '0);
                end
            end
            OP_BRANCH:
            begin
                alu  = 1'b0;
                disp = {{SEXT_W{it.branch_offset[OFFSET_W-1]}}, it.branch_offset, 2'b00};
                val  = arch_regs[PC_INDEX] + disp;
                arch_regs[PC_INDEX] = val;
                wr   = 1'b1;
            end
            default: alu = 1'b0;
        endcase
        if (alu)
        begin
            if (wr)
                arch_regs[it.dest_reg] = val;
            if (it.set_flags)
            begin
                flag_c = cy;
                flag_n = val[DATA_W-1];
                flag_z = (val == '0);
            end
        end
        r.result_value    = val;
        r.result_written  = wr;
        r.flag_neg        = flag_n;
        r.flag_zero       = flag_z;
        r.flag_carry      = flag_c;
        r.program_counter = arch_regs[PC_INDEX];
        return r;
    endfunction

    task automatic check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
        if (got !== want)
        begin
            fail_count++;
            $display("%0t %s expected %h got %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
                arch_regs[i] = '0;
            flag_n = 1'b0;
            flag_z = 1'b0;
            flag_c = 1'b0;
            expected_results.delete();
            queued = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t unexpected result beat %h", $time, result);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("result_value", want.result_value, result.result_value);
                    check_field("result_written", DATA_W'(want.result_written),
                                DATA_W'(result.result_written));
                    check_field("flag_neg", DATA_W'(want.flag_neg), DATA_W'(result.flag_neg));
                    check_field("flag_zero", DATA_W'(want.flag_zero),
                                DATA_W'(result.flag_zero));
                    check_field("flag_carry", DATA_W'(want.flag_carry),
                                DATA_W'(result.flag_carry));
                    check_field("program_counter", want.program_counter,
                                result.program_counter);
                    compared++;
                end
            end
            if (instr_valid && !instr_stall)
                expected_results.push_back(execute_instr(instr));
            queued = expected_results.size();
        end
    end

endmodule

// ===== sim/tb_arm_execute_alu_regfile.sv =====
`timescale 1ns / 1ps
// testbench top for arm_execute_alu_regfile: clock, reset, instruction stimulus and verdict
// depends on aeru_pkg, the execute stage rtl and aeru_result_checker
module tb_arm_execute_alu_regfile;
    import aeru_pkg::*;

    localparam logic [3:0] OP_UNUSED_LO = 4'd12;
    localparam logic [3:0] OP_UNUSED_HI = 4'd15;
    localparam int         PHASE_ITEMS  = 406;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    instr_valid = 1'b0;
    logic    instr_stall;
    instr_t  instr = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    int errors;
    int outstanding;
    int checked;
    int idle_pct = 0;
    int stall_pct = 0;
    int issued = 0;

    logic [DATA_W-1:0] operand_pool [8] = '{32'h0000_0000, 32'h0000_0001, 32'h0000_0002,
                                            32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
                                            32'hffff_fffe, 32'h0001_0000};

    arm_execute_alu_regfile dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .instr_valid  (instr_valid),
        .instr_stall  (instr_stall),
        .instr        (instr),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    aeru_result_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .instr_valid  (instr_valid),
        .instr_stall  (instr_stall),
        .instr        (instr),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .errors       (errors),
        .outstanding  (outstanding),
        .checked      (checked)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
        result_stall <= ($urandom_range(0, 99) < stall_pct);

    function automatic instr_t make_instr(logic [3:0] op, logic [3:0] rd, logic [3:0] rn,
                                          logic [DATA_W-1:0] op2, logic shc, logic s,
                                          logic [3:0] rm, logic [3:0] rs, logic acc,
                                          logic [OFFSET_W-1:0] off);
        instr_t it;
        it.operation     = op;
        it.dest_reg      = rd;
        it.first_reg     = rn;
        it.operand_two   = op2;
        it.shifter_carry = shc;
        it.set_flags     = s;
        it.mul_reg_m     = rm;
        it.mul_reg_s     = rs;
        it.accumulate    = acc;
        it.branch_offset = off;
        return it;
    endfunction

    function automatic instr_t random_instr();
        instr_t      it;
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        it  = instr_t'(raw[$bits(instr_t)-1:0]);
        if ($urandom_range(0, 99) < 4)
            it.operation = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        else if ($urandom_range(0, 99) < 15)
            it.operation = OP_MOV;
        else
            it.operation = 4'($urandom_range(OP_AND, OP_BRANCH));
        if ($urandom_range(0, 2) == 0)
            it.operand_two = operand_pool[3'($urandom_range(0, 7))];
        case ($urandom_range(0, 7))
            0: it.branch_offset = '0;
            1: it.branch_offset = {1'b0, {(OFFSET_W-1){1'b1}}};
            2: it.branch_offset = {1'b1, {(OFFSET_W-1){1'b0}}};
            3: it.branch_offset = '1;
            default: ;
        endcase
        return it;
    endfunction

    task automatic send_instr(instr_t it);
        instr       <= it;
        instr_valid <= 1'b1;
        @(posedge clk);
        while (instr_stall)
            @(posedge clk);
        issued++;
        if ($urandom_range(0, 99) < idle_pct)
        begin
            instr_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < idle_pct)
                @(posedge clk);
        end
    endtask

    initial
    begin
        instr_t it;
        int     count;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, every operation, flag and register corner cases
        send_instr(make_instr(OP_MOV, 4'd0, 4'd0, 32'hffff_ffff, 1'b1, 1'b1, 4'd0, 4'd0, 1'b0, '0));
        send_instr(make_instr(OP_MOV, 4'd1, 4'd0, 32'h0, 1'b0, 1'b1, 4'd0, 4'd0, 1'b0, '0));
        send_instr(make_instr(OP_ADD, 4'd2, 4'd0, 32'h1, 1'b0, 1'b1, 4'd0, 4'd0, 1'b0, '0));
        send_instr(make_instr(OP_SUB, 4'd3, 4'd1, 32'h1, 1'b1, 1'b1, 4'd0, 4'd0, 1'b0, '0));
        send_instr(make_instr(OP_RSB, 4'd4, 4'd0, 32'hffff_ffff, 1'b0, 1'b1, 4'd0, 4'd0, 1'b0, '0));
        send_instr(make_instr(OP_CMP, 4'd9, 4'd0, 32'hffff_ffff, 1'b0, 1'b1, 4'd0, 4'd0, 1'b0, '0));
        send_instr(make_instr(OP_CMP, 4'd9, 4'd1, 32'h8000_0000, 1'b1, 1'b1, 4'd0, 4'd0, 1'b0, '0));
        send_instr(make_instr(OP_TST, 4'd9, 4'd0, 32'h8000_0000, 1'b1, 1'b1, 4'd0, 4'd0, 1'b0, '0));
        send_instr(make_instr(OP_TEQ, 4'd9, 4'd0, 32'hffff_ffff, 1'b0, 1'b1, 4'd0, 4'd0, 1'b0, '0));
        send_instr(make_instr(OP_AND, 4'd5, 4'd0, 32'h0f0f_0f0f, 1'b1, 1'b0, 4'd0, 4'd0, 1'b0, '0));
        send_instr(make_instr(OP_EOR, 4'd6, 4'd5, 32'hffff_ffff, 1'b1, 1'b1, 4'd0, 4'd0, 1'b0, '0));
        send_instr(make_instr(OP_ORR, 4'd7, 4'd5, 32'hf0f0_f0f0, 1'b0, 1'b1, 4'd0, 4'd0, 1'b0, '0));
        send_instr(make_instr(OP_ADD, 4'd0, 4'd0, 32'h7fff_ffff, 1'b0, 1'b1, 4'd0, 4'd0, 1'b0, '0));
        send_instr(make_instr(OP_MUL, 4'd8, 4'd0, 32'h0, 1'b0, 1'b1, 4'd6, 4'd6, 1'b0, '0));
        send_instr(make_instr(OP_MUL, 4'd6, 4'd6, 32'h0, 1'b1, 1'b1, 4'd6, 4'd6, 1'b1, '0));
        send_instr(make_instr(OP_MUL, 4'd10, 4'd2, 32'h0, 1'b0, 1'b0, 4'd5, 4'd7, 1'b0, '0));
        send_instr(make_instr(OP_MOV, 4'd15, 4'd0, 32'h0000_0100, 1'b0, 1'b0, 4'd0, 4'd0,
                              1'b0, '0));
        send_instr(make_instr(OP_BRANCH, 4'd0, 4'd0, 32'h0, 1'b1, 1'b1, 4'd0, 4'd0, 1'b0,
                              24'h7f_ffff));
        send_instr(make_instr(OP_BRANCH, 4'd0, 4'd0, 32'h0, 1'b0, 1'b1, 4'd0, 4'd0, 1'b0,
                              24'h80_0000));
        send_instr(make_instr(OP_BRANCH, 4'd0, 4'd0, 32'h0, 1'b0, 1'b0, 4'd0, 4'd0, 1'b0,
                              24'hff_ffff));
        send_instr(make_instr(OP_ADD, 4'd15, 4'd15, 32'hffff_ffff, 1'b0, 1'b1, 4'd15, 4'd15,
                              1'b1, 24'hff_ffff));
        send_instr(make_instr(OP_UNUSED_LO, 4'd3, 4'd0, 32'hffff_ffff, 1'b1, 1'b1, 4'd0, 4'd0,
                              1'b1, 24'hff_ffff));
        send_instr(make_instr(OP_UNUSED_HI, 4'd15, 4'd15, 32'hffff_ffff, 1'b1, 1'b1, 4'd15,
                              4'd15, 1'b1, 24'hff_ffff));

        // random: four pacing phases
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 79; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 79; end
                default: begin idle_pct = 7; stall_pct = 7; end
            endcase
            count = 0;
            while (count < PHASE_ITEMS)
            begin
                it = random_instr();
                send_instr(it);
                if (it.operation <= OP_BRANCH)
                    count++;
            end
        end
        instr_valid <= 1'b0;
        stall_pct = 0;
        @(posedge clk);

        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("%0d instructions issued over four pacing phases, %0d result beats checked",
                 issued, checked);
        if (errors == 0)
            $display("arm_execute_alu_regfile: match");
        else
            $display("arm_execute_alu_regfile: mismatch");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("timeout with %0d beats outstanding", outstanding);
        $display("arm_execute_alu_regfile: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/aeru_pkg.sv
rtl/core/aeru_ram.sv
rtl/core/aeru_regfile.sv
rtl/core/aeru_alu.sv
rtl/core/arm_execute_alu_regfile.sv
sim/aeru_result_checker.sv
sim/tb_arm_execute_alu_regfile.sv
